// ----- sv/wcc_pkg.sv -----
`timescale 1ns / 1ps

package wcc_pkg;

  // Field widths
  localparam int COLOR_W = 24;
  localparam int CH_W    = 8;
  localparam int N_CH    = 3;
  localparam int RATIO_W = 13;

  // Luminance datapath
  localparam int LIN_W   = 17;                  // Q0.16, 1.0 included
  localparam int WGT_W   = 16;                  // Q0.16 weights
  localparam int PROD_W  = 32;                  // one weighted channel
  localparam int SUM_W   = PROD_W + 1;          // three channels plus rounding
  localparam int LUM_W   = 17;                  // Q0.16, 0..65536
  localparam int LUM_FRAC = 16;

  localparam logic [WGT_W-1:0] LUM_WEIGHT [N_CH] = '{16'd13933, 16'd46871, 16'd4732};
  localparam logic [SUM_W-1:0] LUM_ROUND  = SUM_W'(32768);
  localparam logic [LUM_W-1:0] LUM_OFFSET = LUM_W'(3277);  // 0.05
  localparam logic [LUM_W-1:0] LUM_ONE    = LUM_W'(65536);

  // Ratio divider: (512*n + d) / (2*d), quotient below 2^13
  localparam int RATIO_FRAC = 8;
  localparam int NUM_W  = 26;
  localparam int DEN_W  = LUM_W + 1;
  localparam int QUO_W  = RATIO_W;
  localparam int CMP_W  = DEN_W + QUO_W - 1;

  localparam logic [RATIO_W-1:0] RATIO_MAX = RATIO_W'(5376);  // 21.0
  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(256);   // 1.0

  // Pipeline depths
  localparam int LUM_STAGES = 3;
  localparam int DIV_STAGES = QUO_W + 2;

  typedef logic [LIN_W-1:0] lin_tab_t [256];

  typedef struct packed {
    logic [LUM_W-1:0]   lum_fg;
    logic [LUM_W-1:0]   lum_bg;
    logic [RATIO_W-1:0] req;
  } lum_pair_t;

  // x^5 in Q2.30, truncating after each product
  function automatic longint unsigned pow5_q30(longint unsigned r);
    longint unsigned t;
    t = (r * r) >> 30;
    t = (t * t) >> 30;
    t = (t * r) >> 30;
    return t;
  endfunction

  // sRGB decode curve, evaluated at elaboration only
  function automatic lin_tab_t build_lin_table();
    lin_tab_t        tab;
    longint unsigned x;
    longint unsigned y;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned v;
    longint unsigned num;
    int              c;
    for (c = 0; c < 256; c++) begin
      if (c <= 10) begin
        // linear segment c/(255*12.92), halves up
        num = longint'(c) * 64'd13107200 + 64'd329460;
        tab[c] = LIN_W'(num / 64'd658920);
      end else begin
        x  = ((longint'(c) * 64'd1000 + 64'd14025) << 30) / 64'd269025;
        y  = (x * x) >> 30;
        lo = 64'd0;
        hi = 64'd1 << 30;
        // fifth root of x^2 by bisection
        while (lo < hi) begin
          mid = lo + ((hi - lo + 64'd1) >> 1);
          if (pow5_q30(mid) <= y) begin
            lo = mid;
          end else begin
            hi = mid - 64'd1;
          end
        end
        v = (y * lo) >> 30;
        tab[c] = LIN_W'((v + 64'd8192) >> 14);
      end
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TABLE = build_lin_table();

endpackage

// ----- sv/wcc_if.sv -----
`timescale 1ns / 1ps

interface wcc_in_if;
  logic                          valid;
  logic                          ready;
  logic [wcc_pkg::COLOR_W-1:0]   fg_color;
  logic [wcc_pkg::COLOR_W-1:0]   bg_color;
  logic [wcc_pkg::RATIO_W-1:0]   required_ratio;

  modport source (output valid, output fg_color, output bg_color,
                  output required_ratio, input ready);
  modport sink   (input valid, input fg_color, input bg_color,
                  input required_ratio, output ready);
endinterface

interface wcc_out_if;
  logic                          valid;
  logic                          ready;
  logic [wcc_pkg::RATIO_W-1:0]   ratio;
  logic                          meets_requirement;

  modport source (output valid, output ratio, output meets_requirement, input ready);
  modport sink   (input valid, input ratio, input meets_requirement, output ready);
endinterface

// ----- sv/wcc_lum_pipe.sv -----
`timescale 1ns / 1ps

module wcc_lum_pipe (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [wcc_pkg::COLOR_W-1:0] fg_color,
  input  logic [wcc_pkg::COLOR_W-1:0] bg_color,
  input  logic [wcc_pkg::RATIO_W-1:0] required_ratio,
  output logic                        out_valid,
  input  logic                        out_ready,
  output wcc_pkg::lum_pair_t          out_data
);

  logic [wcc_pkg::LUM_STAGES-1:0] v_r;
  logic [wcc_pkg::LUM_STAGES:0]   en;

  logic [wcc_pkg::LIN_W-1:0]   fg_lin_r  [wcc_pkg::N_CH];
  logic [wcc_pkg::LIN_W-1:0]   bg_lin_r  [wcc_pkg::N_CH];
  logic [wcc_pkg::PROD_W-1:0]  fg_prod_r [wcc_pkg::N_CH];
  logic [wcc_pkg::PROD_W-1:0]  bg_prod_r [wcc_pkg::N_CH];
  logic [wcc_pkg::RATIO_W-1:0] req_r     [wcc_pkg::LUM_STAGES];
  logic [wcc_pkg::LUM_W-1:0]   lum_fg_r;
  logic [wcc_pkg::LUM_W-1:0]   lum_bg_r;

  logic [wcc_pkg::SUM_W-1:0]   fg_sum_nxt;
  logic [wcc_pkg::SUM_W-1:0]   bg_sum_nxt;

  // stage advances when empty or when the next one advances
  assign en[wcc_pkg::LUM_STAGES] = out_ready;
  genvar k;
  generate
    for (k = 0; k < wcc_pkg::LUM_STAGES; k++) begin : g_en
      assign en[k] = !v_r[k] || en[k+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int s = 1; s < wcc_pkg::LUM_STAGES; s++) begin
        if (en[s]) v_r[s] <= v_r[s-1];
      end
    end
  end

  // stage 0: decode table, red at the top byte
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int ch = 0; ch < wcc_pkg::N_CH; ch++) begin
        fg_lin_r[ch] <= wcc_pkg::LIN_TABLE[
                          fg_color[wcc_pkg::CH_W*(wcc_pkg::N_CH-1-ch) +: wcc_pkg::CH_W]];
        bg_lin_r[ch] <= wcc_pkg::LIN_TABLE[
                          bg_color[wcc_pkg::CH_W*(wcc_pkg::N_CH-1-ch) +: wcc_pkg::CH_W]];
      end
      req_r[0] <= required_ratio;
    end
  end

  // stage 1: weighted channels
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int ch = 0; ch < wcc_pkg::N_CH; ch++) begin
        fg_prod_r[ch] <= wcc_pkg::PROD_W'(fg_lin_r[ch]) *
                         wcc_pkg::PROD_W'(wcc_pkg::LUM_WEIGHT[ch]);
        bg_prod_r[ch] <= wcc_pkg::PROD_W'(bg_lin_r[ch]) *
                         wcc_pkg::PROD_W'(wcc_pkg::LUM_WEIGHT[ch]);
      end
      req_r[1] <= req_r[0];
    end
  end

  // stage 2: sum, round, back to Q0.16
  assign fg_sum_nxt = wcc_pkg::SUM_W'(fg_prod_r[0]) + wcc_pkg::SUM_W'(fg_prod_r[1]) +
                      wcc_pkg::SUM_W'(fg_prod_r[2]) + wcc_pkg::LUM_ROUND;
  assign bg_sum_nxt = wcc_pkg::SUM_W'(bg_prod_r[0]) + wcc_pkg::SUM_W'(bg_prod_r[1]) +
                      wcc_pkg::SUM_W'(bg_prod_r[2]) + wcc_pkg::LUM_ROUND;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      lum_fg_r <= fg_sum_nxt[wcc_pkg::LUM_FRAC +: wcc_pkg::LUM_W];
      lum_bg_r <= bg_sum_nxt[wcc_pkg::LUM_FRAC +: wcc_pkg::LUM_W];
      req_r[2] <= req_r[1];
    end
  end

  assign in_ready        = en[0];
  assign out_valid       = v_r[wcc_pkg::LUM_STAGES-1];
  assign out_data.lum_fg = lum_fg_r;
  assign out_data.lum_bg = lum_bg_r;
  assign out_data.req    = req_r[wcc_pkg::LUM_STAGES-1];

  // weights sum to 1.0, so luminance never exceeds 1.0
  a_lum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (lum_fg_r <= wcc_pkg::LUM_ONE && lum_bg_r <= wcc_pkg::LUM_ONE))
    else $error("luminance above 1.0");

endmodule

// ----- sv/wcc_div_pipe.sv -----
`timescale 1ns / 1ps

module wcc_div_pipe (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  wcc_pkg::lum_pair_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [wcc_pkg::RATIO_W-1:0] ratio,
  output logic                        meets_requirement
);

  logic [wcc_pkg::DIV_STAGES-1:0] v_r;
  logic [wcc_pkg::DIV_STAGES:0]   en;

  logic [wcc_pkg::NUM_W-1:0]   rem_r [wcc_pkg::QUO_W+1];
  logic [wcc_pkg::DEN_W-1:0]   den_r [wcc_pkg::QUO_W+1];
  logic [wcc_pkg::QUO_W-1:0]   q_r   [wcc_pkg::QUO_W+1];
  logic [wcc_pkg::RATIO_W-1:0] req_r [wcc_pkg::QUO_W+1];
  logic [wcc_pkg::RATIO_W-1:0] ratio_r;
  logic                        meets_r;

  logic [wcc_pkg::LUM_W-1:0]   n_nxt;
  logic [wcc_pkg::LUM_W-1:0]   d_nxt;
  logic [wcc_pkg::RATIO_W-1:0] ratio_nxt;

  assign en[wcc_pkg::DIV_STAGES] = out_ready;
  genvar k;
  generate
    for (k = 0; k < wcc_pkg::DIV_STAGES; k++) begin : g_en
      assign en[k] = !v_r[k] || en[k+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int s = 1; s < wcc_pkg::DIV_STAGES; s++) begin
        if (en[s]) v_r[s] <= v_r[s-1];
      end
    end
  end

  // stage 0: lighter over darker, both offset by 0.05
  always_comb begin
    if (in_data.lum_fg > in_data.lum_bg) begin
      n_nxt = in_data.lum_fg + wcc_pkg::LUM_OFFSET;
      d_nxt = in_data.lum_bg + wcc_pkg::LUM_OFFSET;
    end else begin
      n_nxt = in_data.lum_bg + wcc_pkg::LUM_OFFSET;
      d_nxt = in_data.lum_fg + wcc_pkg::LUM_OFFSET;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      // (512n + d) / 2d gives Q5.8 rounded half up
      rem_r[0] <= (wcc_pkg::NUM_W'(n_nxt) << (wcc_pkg::RATIO_FRAC + 1)) +
                  wcc_pkg::NUM_W'(d_nxt);
      den_r[0] <= wcc_pkg::DEN_W'(d_nxt) << 1;
      q_r[0]   <= '0;
      req_r[0] <= in_data.req;
    end
  end

  // stages 1..QUO_W: restoring division, one quotient bit each, MSB first
  generate
    for (k = 1; k <= wcc_pkg::QUO_W; k++) begin : g_div
      localparam int B = wcc_pkg::QUO_W - k;
      logic [wcc_pkg::CMP_W-1:0] rem_ext;
      logic [wcc_pkg::CMP_W-1:0] trial;
      logic                      fits;

      assign rem_ext = wcc_pkg::CMP_W'(rem_r[k-1]);
      assign trial   = wcc_pkg::CMP_W'(den_r[k-1]) << B;
      assign fits    = rem_ext >= trial;

      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem_r[k] <= fits ? wcc_pkg::NUM_W'(rem_ext - trial) : rem_r[k-1];
          q_r[k]   <= fits ? (q_r[k-1] | (wcc_pkg::QUO_W'(1) << B)) : q_r[k-1];
          den_r[k] <= den_r[k-1];
          req_r[k] <= req_r[k-1];
        end
      end
    end
  endgenerate

  // last stage: clamp at 21.0 and compare, doubles as output register
  assign ratio_nxt = (q_r[wcc_pkg::QUO_W] > wcc_pkg::RATIO_MAX) ?
                     wcc_pkg::RATIO_MAX : q_r[wcc_pkg::QUO_W];

  always_ff @(posedge clk) begin
    if (en[wcc_pkg::DIV_STAGES-1]) begin
      ratio_r <= ratio_nxt;
      meets_r <= ratio_nxt >= req_r[wcc_pkg::QUO_W];
    end
  end

  assign in_ready          = en[0];
  assign out_valid         = v_r[wcc_pkg::DIV_STAGES-1];
  assign ratio             = ratio_r;
  assign meets_requirement = meets_r;

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[wcc_pkg::QUO_W] |->
      rem_r[wcc_pkg::QUO_W] < wcc_pkg::NUM_W'(den_r[wcc_pkg::QUO_W]))
    else $error("divider remainder not below divisor");

  a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (ratio_r >= wcc_pkg::RATIO_ONE && ratio_r <= wcc_pkg::RATIO_MAX))
    else $error("ratio outside 1.0 to 21.0");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !v_r[wcc_pkg::DIV_STAGES-1])
    else $error("result valid right after reset");

endmodule

// ----- sv/wcag_contrast_check_core.sv -----
`timescale 1ns / 1ps

// Channel  Dir  Fields                                   Handshake
// -------  ---  ---------------------------------------  ---------------
// in_ch    in   fg_color[24] bg_color[24] required[13]    valid/ready
// out_ch   out  ratio[13] (Q5.8) meets_requirement[1]     valid/ready
//
// One request per cycle sustained while out_ch.ready stays high; stages in order:
// 3 luminance stages, 1 ratio setup, 13 divider bit stages, 1 clamp/compare.
// The divider is fully unrolled: one quotient bit per stage.
// Synchronous active-low reset clears only the valid bits; payload is not reset.
// Each stage moves when it is empty or the one after it moves, so bubbles
// close up and a stalled output holds its request while the front keeps filling.

module wcag_contrast_check_core (
  input logic       clk,
  input logic       rst_n,
  wcc_in_if.sink    in_ch,
  wcc_out_if.source out_ch
);

  // luminance -> divider hand-off
  logic               lum_valid;
  logic               lum_ready;
  wcc_pkg::lum_pair_t lum_data;

  // Front end: gamma decode through the constant table, then the
  // 0.2126 / 0.7152 / 0.0722 weighted sum for both colors side by side.
  wcc_lum_pipe u_lum (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .fg_color       (in_ch.fg_color),
    .bg_color       (in_ch.bg_color),
    .required_ratio (in_ch.required_ratio),
    .out_valid      (lum_valid),
    .out_ready      (lum_ready),
    .out_data       (lum_data)
  );

  // Back end: (L_hi + 0.05) / (L_lo + 0.05) as Q5.8, clamped at 21.0,
  // and the pass flag against the requested minimum (exact compare).
  wcc_div_pipe u_div (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (lum_valid),
    .in_ready          (lum_ready),
    .in_data           (lum_data),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .ratio             (out_ch.ratio),
    .meets_requirement (out_ch.meets_requirement)
  );

endmodule

// ----- tb/sv/wcag_contrast_check_core_tb.sv -----
`timescale 1ns / 1ps

module wcag_contrast_check_core_tb;

  localparam int CW = wcc_pkg::COLOR_W;
  localparam int RW = wcc_pkg::RATIO_W;

  // luminance weights and the 0.05 flare term, Q0.16
  localparam longint unsigned WT_RED   = 64'd13933;
  localparam longint unsigned WT_GREEN = 64'd46871;
  localparam longint unsigned WT_BLUE  = 64'd4732;
  localparam longint unsigned FLARE    = 64'd3277;
  localparam longint unsigned Q30_ONE  = 64'd1 << 30;

  localparam logic [RW-1:0] Q88_ONE  = RW'(256);
  localparam logic [RW-1:0] Q88_CEIL = RW'(5376);

  localparam int PHASE_REQS   = 611;
  localparam int BURST_REQS   = 80;
  localparam int SINK_HOLD    = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_PRINTS   = 30;

  typedef struct packed {
    logic [RW-1:0] ratio;
    logic          meets;
  } verdict_t;

  typedef struct packed {
    verdict_t      v;
    logic [CW-1:0] fg;
    logic [CW-1:0] bg;
    logic [RW-1:0] req;
  } pending_t;

  typedef struct packed {
    logic [CW-1:0] fg;
    logic [CW-1:0] bg;
    logic [RW-1:0] req;
    logic          typed;
    verdict_t      v;
  } dir_row_t;

  // typed rows carry their answer; the rest go through the predictor
  localparam int N_DIR = 18;
  localparam dir_row_t DIR_TABLE [N_DIR] = '{
    '{24'h000000, 24'hFFFFFF, 13'd0,    1'b1, '{Q88_CEIL, 1'b1}},
    '{24'hFFFFFF, 24'h000000, 13'd5376, 1'b1, '{Q88_CEIL, 1'b1}},
    '{24'h000000, 24'hFFFFFF, 13'd5377, 1'b1, '{Q88_CEIL, 1'b0}},
    '{24'hFFFFFF, 24'h000000, 13'h1FFF, 1'b1, '{Q88_CEIL, 1'b0}},
    '{24'h000000, 24'h000000, 13'd256,  1'b1, '{Q88_ONE,  1'b1}},
    '{24'hFFFFFF, 24'hFFFFFF, 13'd257,  1'b1, '{Q88_ONE,  1'b0}},
    '{24'h123456, 24'h123456, 13'd0,    1'b1, '{Q88_ONE,  1'b1}},
    '{24'hAAAAAA, 24'hAAAAAA, 13'h1555, 1'b1, '{Q88_ONE,  1'b0}},
    '{24'hFF0000, 24'h000000, 13'd1152, 1'b0, '0},
    '{24'h00FF00, 24'h000000, 13'd1152, 1'b0, '0},
    '{24'h0000FF, 24'hFFFFFF, 13'd768,  1'b0, '0},
    '{24'h0A0A0A, 24'h0B0B0B, 13'd256,  1'b0, '0},
    '{24'h010101, 24'h000000, 13'd257,  1'b0, '0},
    '{24'hFEFEFE, 24'hFFFFFF, 13'd256,  1'b0, '0},
    '{24'h777777, 24'hFFFFFF, 13'd1152, 1'b0, '0},
    '{24'hFFFFFF, 24'h767676, 13'd1152, 1'b0, '0},
    '{24'h555555, 24'hAAAAAA, 13'h0AAA, 1'b0, '0},
    '{24'hAAAAAA, 24'h555555, 13'h1555, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  wcc_in_if  in_if ();
  wcc_out_if out_if ();

  wcag_contrast_check_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [16:0] lin_lut [256];
  pending_t    verdict_q [$];

  int       src_idle_pct = 0;
  int       snk_idle_pct = 0;
  int       hold_reqs    = 0;
  int       held_cycles  = 0;
  int       in_stalls    = 0;
  int       sent_reqs    = 0;
  int       checked      = 0;
  int       mismatches   = 0;
  int       cycle_cnt    = 0;
  logic     tag_typed;
  verdict_t tag_verdict;

  // ---------------- predictor ----------------

  function automatic longint unsigned cube_sq_q30(longint unsigned r);
    longint unsigned t;
    t = (r * r) >> 30;
    t = (t * t) >> 30;
    t = (t * r) >> 30;
    return t;
  endfunction

  // sRGB code to linear light, Q0.16 with 1.0 = 65536
  function automatic logic [16:0] decode_channel(int c);
    longint unsigned cu;
    longint unsigned x;
    longint unsigned y;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned v;
    cu = longint'(c);
    if (c <= 10) begin
      return 17'((cu * 64'd13107200 + 64'd329460) / 64'd658920);
    end
    x  = ((cu * 64'd1000 + 64'd14025) << 30) / 64'd269025;
    y  = (x * x) >> 30;
    lo = 64'd0;
    hi = Q30_ONE;
    // x^2.4 = x^2 * (x^2)^(1/5), fifth root by bisection
    while (lo < hi) begin
      mid = lo + ((hi - lo + 64'd1) >> 1);
      if (cube_sq_q30(mid) <= y) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    v = (y * lo) >> 30;
    return 17'((v + 64'd8192) >> 14);
  endfunction

  function automatic longint unsigned rel_luminance(logic [CW-1:0] rgb);
    longint unsigned s;
    s = WT_RED * lin_lut[rgb[23:16]] + WT_GREEN * lin_lut[rgb[15:8]] +
        WT_BLUE * lin_lut[rgb[7:0]] + 64'd32768;
    return s >> 16;
  endfunction

  function automatic verdict_t contrast_verdict(logic [CW-1:0] fg, logic [CW-1:0] bg,
                                                logic [RW-1:0] req);
    longint unsigned lf;
    longint unsigned lb;
    longint unsigned n;
    longint unsigned d;
    longint unsigned q;
    verdict_t        v;
    lf = rel_luminance(fg);
    lb = rel_luminance(bg);
    n  = ((lf > lb) ? lf : lb) + FLARE;
    d  = ((lf > lb) ? lb : lf) + FLARE;
    q  = (n * 64'd512 + d) / (64'd2 * d);
    if (q > 64'(Q88_CEIL)) q = 64'(Q88_CEIL);
    v.ratio = RW'(q);
    v.meets = (q >= 64'(req));
    return v;
  endfunction

  // ---------------- checking ----------------

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin : scoreboard
    pending_t head;
    pending_t rec;
    verdict_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      checked++;
      if (verdict_q.size() == 0) begin
        flag_mismatch($sformatf("result ratio=%0d with no request pending", out_if.ratio));
      end else begin
        head = verdict_q.pop_front();
        if (out_if.ratio !== head.v.ratio)
          flag_mismatch($sformatf("fg=%06h bg=%06h req=%0d ratio got %0d want %0d",
                                  head.fg, head.bg, head.req, out_if.ratio, head.v.ratio));
        if (out_if.meets_requirement !== head.v.meets)
          flag_mismatch($sformatf("fg=%06h bg=%06h req=%0d meets got %b want %b",
                                  head.fg, head.bg, head.req,
                                  out_if.meets_requirement, head.v.meets));
      end
    end
    if (rst_n === 1'b1 && in_if.valid === 1'b1) begin
      if (in_if.ready === 1'b1) begin
        want = tag_typed ? tag_verdict
                         : contrast_verdict(in_if.fg_color, in_if.bg_color,
                                            in_if.required_ratio);
        rec  = '{want, in_if.fg_color, in_if.bg_color, in_if.required_ratio};
        verdict_q.insert(verdict_q.size(), rec);
      end else begin
        in_stalls++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_cnt,
               verdict_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------- result side ----------------

  initial begin : sink_side
    int left;
    int seen;
    left = 0;
    seen = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != seen) begin
        seen = hold_reqs;
        left = SINK_HOLD;
      end
      if (left > 0) begin
        left--;
        held_cycles++;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // ---------------- request side ----------------

  task automatic offer_request(input logic [CW-1:0] fg, input logic [CW-1:0] bg,
                               input logic [RW-1:0] req, input logic typed,
                               input verdict_t typed_v);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.fg_color       <= fg;
    in_if.bg_color       <= bg;
    in_if.required_ratio <= req;
    tag_typed            <= typed;
    tag_verdict          <= typed_v;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    sent_reqs++;
  endtask

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'h01;
      2:       return 8'h0A;
      3:       return 8'h0B;
      4:       return 8'hFE;
      5:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_random_request();
    logic [CW-1:0] fg;
    logic [CW-1:0] bg;
    logic [RW-1:0] req;
    verdict_t      v;
    int            mode;
    int            near;
    fg   = CW'($urandom);
    bg   = CW'($urandom);
    mode = $urandom_range(99);
    if (mode < 20) begin
      fg = {pick_channel(), pick_channel(), pick_channel()};
      bg = {pick_channel(), pick_channel(), pick_channel()};
    end else if (mode < 35) begin
      bg = $urandom_range(1) ? fg : fg ^ (CW'(1) << $urandom_range(CW - 1));
    end
    mode = $urandom_range(99);
    if (mode < 35) begin
      req = RW'($urandom_range(8191));
    end else if (mode < 85) begin
      // land on or right around the threshold
      v    = contrast_verdict(fg, bg, '0);
      near = int'(v.ratio) + int'($urandom_range(6)) - 3;
      req  = RW'((near < 0) ? 0 : near);
    end else begin
      req = RW'($urandom_range(5376, 256));
    end
    offer_request(fg, bg, req, 1'b0, '0);
  endtask

  // always waits on the clock before the first check so the last accepted request is queued first
  task automatic wait_drained();
    do @(posedge clk); while (verdict_q.size() != 0);
  endtask

  initial begin : request_side
    int i;
    for (i = 0; i < 256; i++) lin_lut[i] = decode_channel(i);

    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.fg_color       = '0;
    in_if.bg_color       = '0;
    in_if.required_ratio = '0;
    tag_typed            = 1'b0;
    tag_verdict          = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender sparse-ish, sink mostly stalled
    src_idle_pct = 30;
    snk_idle_pct = 76;
    for (i = 0; i < N_DIR; i++)
      offer_request(DIR_TABLE[i].fg, DIR_TABLE[i].bg, DIR_TABLE[i].req,
                    DIR_TABLE[i].typed, DIR_TABLE[i].v);
    for (i = 0; i < PHASE_REQS; i++) send_random_request();

    // sender holds back until the pipe is empty before the next phase
    in_if.valid <= 1'b0;
    wait_drained();
    src_idle_pct = 76;
    snk_idle_pct = 30;
    for (i = 0; i < PHASE_REQS; i++) send_random_request();

    in_if.valid <= 1'b0;
    wait_drained();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    // long sink hold-off while requests keep coming: fills the pipe, stalls input
    hold_reqs <= hold_reqs + 1;
    for (i = 0; i < BURST_REQS; i++) send_random_request();
    for (i = BURST_REQS; i < PHASE_REQS; i++) send_random_request();
    in_if.valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("coverage: %0d color pairs (%0d directed), %0d results checked",
             sent_reqs, N_DIR, checked);
    $display("coverage: sink hold-off %0d cycles, input back-pressure %0d cycles, %0d bad",
             held_cycles, in_stalls, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/wcc_pkg.sv
sv/wcc_if.sv
sv/wcc_lum_pipe.sv
sv/wcc_div_pipe.sv
sv/wcag_contrast_check_core.sv
tb/sv/wcag_contrast_check_core_tb.sv
